// File: hw/rtl/rcs_pkg.sv
// Shared types and constants of the random controller sweep unit.
package rcs_pkg;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_CONTROLLER = 3'd0;
	localparam logic [2:0] REG_LOW_BOUND  = 3'd1;
	localparam logic [2:0] REG_HIGH_BOUND = 3'd2;
	localparam logic [2:0] REG_MULTIPLIER = 3'd3;
	localparam logic [2:0] REG_QUANTIZE   = 3'd4;
	localparam logic [2:0] REG_EIGHTHS    = 3'd5;
	localparam logic [2:0] REG_DENSITY    = 3'd6;

	// Width of the shared divider; it covers the full 33-bit sweep length.
	localparam int DIV_W     = 33;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	// Request to the shared divider.
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	// Response of the shared divider.
	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
		logic [DIV_W-1:0] remainder;
	} div_rsp_t;

endpackage

// File: hw/rtl/rcs_div.sv
// Shared restoring divider, one quotient bit per cycle.
module rcs_div import rcs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_W-1:0]     dvd_q;
	logic [DIV_W-1:0]     den_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_W:0]       shifted;
	logic [DIV_W+1:0]     trial;
	logic                 ge;

	// Bring down the next dividend bit and try the subtraction.
	assign shifted = {rem_q, dvd_q[DIV_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};
	assign ge      = !trial[DIV_W+1];

	// Sequencing of the iterations.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder and quotient, which shifts in where the dividend shifts out.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;

endmodule

// File: hw/rtl/random_controller_sweep_unit.sv
// Random controller sweep unit: one note-on transaction in, a run of control changes out.
// Each note-on transaction draws a target controller value between the low and high bound
// registers and produces a run of control changes that ramps from the value stored by the
// previous run toward the target, one point every density*10 ticks, closed by the target
// itself at the end of the sweep; a sweep of one tick or less gives only the target at the
// start time and leaves the stored value alone. Other transactions give no results. A run
// whose ramp would exceed MAX_POINTS points is cut to MAX_POINTS ramp points and flags
// truncated on every result. The three divisions of a run (doubled quantize by eighths,
// sweep length by spacing, value difference by step count) share one restoring divider and
// run one after another before the first result; the remaining points then follow one per
// cycle while the output register is not stalled.
// The unit takes no new input until the last result of a run is in the output register.
module random_controller_sweep_unit import rcs_pkg::*; #(
	parameter int MAX_POINTS = 63,
	parameter int TIME_BITS  = 48
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration channel.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [2:0]             cfg_index,
	input  logic [23:0]            cfg_data,
	// Input channel.
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   is_note_on,
	input  logic [TIME_BITS-1:0]   start_time,
	input  logic [15:0]            random_draw,
	// Output channel.
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [6:0]             controller,
	output logic [6:0]             value,
	output logic [TIME_BITS:0]     event_time,
	output logic                   last,
	output logic                   truncated
);

	localparam int TW   = TIME_BITS + 1;
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int SP_W = 13;

	// Sequencer states.
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIV_Q = 4'd1;
	localparam logic [3:0] ST_CHK   = 4'd2;
	localparam logic [3:0] ST_DIV_S = 4'd3;
	localparam logic [3:0] ST_SETUP = 4'd4;
	localparam logic [3:0] ST_DIV_D = 4'd5;
	localparam logic [3:0] ST_RAMP  = 4'd6;
	localparam logic [3:0] ST_TGT   = 4'd7;

	// Maps the eighths register onto the divisors 2, 3, 5 and 7.
	function automatic logic [2:0] eff_eighths(input logic [2:0] e);
		priority if (e <= 3'd2) return 3'd2;
		else if (e <= 3'd4) return 3'd3;
		else if (e <= 3'd6) return 3'd5;
		else return 3'd7;
	endfunction

	// Configuration registers.
	logic [6:0]  ctrl_num_q;
	logic [6:0]  min_q;
	logic [6:0]  max_q;
	logic [7:0]  mult_q;
	logic [23:0] quant_q;
	logic [2:0]  eighths_q;
	logic [8:0]  density_q;

	// Run state.
	logic [3:0]          state_q;
	logic [6:0]          prev_q;
	logic [6:0]          target_q;
	logic [TIME_BITS-1:0] start_q;
	logic [DIV_W-1:0]    dur_q;
	logic [DIV_W-1:0]    steps_q;
	logic [CW-1:0]       emit_q;
	logic [CW-1:0]       cnt_q;
	logic                trunc_q;
	logic                short_q;
	logic signed [8:0]   qd_q;
	logic [DIV_W-1:0]    rd_q;
	logic [DIV_W-1:0]    acc_q;
	logic signed [8:0]   qa_q;
	logic [TW-1:0]       time_q;

	// Output register.
	logic        out_valid_q;
	logic [6:0]  ctrl_out_q;
	logic [6:0]  value_q;
	logic [TW-1:0] etime_q;
	logic        last_q;
	logic        trunc_out_q;

	// Combinational signals.
	logic              in_fire;
	logic              out_free;
	logic [6:0]        lo;
	logic [6:0]        hi;
	logic [6:0]        span;
	logic [22:0]       prod;
	logic [7:0]        tsum;
	logic [6:0]        tgt;
	logic [8:0]        dens_eff;
	logic [SP_W-1:0]   sp;
	logic [7:0]        diff;
	logic              neg;
	logic [7:0]        absd;
	logic [DIV_W:0]    n_pts;
	logic              trunc_n;
	logic              rem_nz;
	logic [8:0]        qmag;
	logic [DIV_W:0]    acc_sum;
	logic              carry;
	logic [DIV_W:0]    acc_next;
	logic signed [8:0] qa_next;
	logic [8:0]        val_sum;
	logic [CW-1:0]     cnt_next;
	logic [63:0]       end_time;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Random target: lo + draw * (hi - lo) / 65536, held within the range.
	assign lo   = (min_q < max_q) ? min_q : max_q;
	assign hi   = (min_q < max_q) ? max_q : min_q;
	assign span = hi - lo;
	assign prod = {7'd0, random_draw} * {16'd0, span};
	assign tsum = {1'b0, lo} + {1'b0, prod[22:16]};
	assign tgt  = (tsum > {1'b0, hi}) ? hi : tsum[6:0];

	// Point spacing, density * 10 with a zero density treated as one.
	assign dens_eff = (density_q == 9'd0) ? 9'd1 : density_q;
	assign sp       = {1'b0, dens_eff, 3'b000} + {3'b000, dens_eff, 1'b0};

	// Signed distance from the stored value to the target.
	assign diff = {1'b0, target_q} - {1'b0, prev_q};
	assign neg  = diff[7];
	assign absd = neg ? (8'd0 - diff) : diff;

	// Point count and truncation from the sweep-length division.
	assign rem_nz  = (div_rsp.remainder != '0);
	assign n_pts   = {1'b0, div_rsp.quotient} + {{DIV_W{1'b0}}, rem_nz};
	assign trunc_n = (n_pts > (DIV_W + 1)'(MAX_POINTS));
	assign qmag    = {1'b0, div_rsp.quotient[7:0]};

	// Ramp stepping: the fractional part accumulates and carries into the offset.
	assign acc_sum  = {1'b0, acc_q} + {1'b0, rd_q};
	assign carry    = (acc_sum >= {1'b0, steps_q});
	assign acc_next = carry ? (acc_sum - {1'b0, steps_q}) : acc_sum;
	assign qa_next  = qa_q + qd_q + $signed({8'd0, carry});
	assign val_sum  = {2'b00, prev_q} + qa_next;
	assign cnt_next = cnt_q + 1'b1;

	assign end_time = 64'(start_q) + 64'(dur_q);

	// Divider requests issued by the sequencer.
	always_comb begin
		div_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				div_req.start    = in_fire && is_note_on;
				div_req.dividend = DIV_W'({quant_q, 1'b0});
				div_req.divisor  = DIV_W'(eff_eighths(eighths_q));
			end
			ST_CHK: begin
				div_req.start    = (dur_q > DIV_W'(1));
				div_req.dividend = dur_q;
				div_req.divisor  = DIV_W'(sp);
			end
			ST_SETUP: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(absd);
				div_req.divisor  = steps_q;
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	rcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_num_q <= 7'd10;
			min_q      <= 7'd0;
			max_q      <= 7'd127;
			mult_q     <= 8'd1;
			quant_q    <= 24'd1;
			eighths_q  <= 3'd2;
			density_q  <= 9'd42;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CONTROLLER: ctrl_num_q <= cfg_data[6:0];
				REG_LOW_BOUND:  min_q      <= cfg_data[6:0];
				REG_HIGH_BOUND: max_q      <= cfg_data[6:0];
				REG_MULTIPLIER: mult_q     <= cfg_data[7:0];
				REG_QUANTIZE:   quant_q    <= cfg_data;
				REG_EIGHTHS:    eighths_q  <= cfg_data[2:0];
				REG_DENSITY:    density_q  <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and stored previous value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prev_q  <= 7'd64;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (in_fire && is_note_on) state_q <= ST_DIV_Q;
				ST_DIV_Q: if (div_rsp.done) state_q <= ST_CHK;
				ST_CHK:   state_q <= (dur_q > DIV_W'(1)) ? ST_DIV_S : ST_TGT;
				ST_DIV_S: if (div_rsp.done) state_q <= ST_SETUP;
				ST_SETUP: state_q <= ST_DIV_D;
				ST_DIV_D: if (div_rsp.done) state_q <= ST_RAMP;
				ST_RAMP:  if (out_free && cnt_next == emit_q) state_q <= ST_TGT;
				ST_TGT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (!short_q) prev_q <= target_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Run datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					target_q <= tgt;
					start_q  <= start_time;
				end
			end
			ST_DIV_Q: begin
				if (div_rsp.done) begin
					dur_q <= {25'd0, mult_q} * {8'd0, div_rsp.quotient[24:0]};
				end
			end
			ST_CHK: begin
				short_q <= (dur_q <= DIV_W'(1));
				trunc_q <= 1'b0;
			end
			ST_DIV_S: begin
				if (div_rsp.done) begin
					steps_q <= div_rsp.quotient + 1'b1;
					trunc_q <= trunc_n;
					emit_q  <= trunc_n ? CW'(MAX_POINTS) : n_pts[CW-1:0];
				end
			end
			ST_DIV_D: begin
				if (div_rsp.done) begin
					// Floor division of the signed distance by the step count.
					if (neg && rem_nz) begin
						qd_q <= 9'sd0 - $signed(qmag + 9'd1);
						rd_q <= steps_q - div_rsp.remainder;
					end else if (neg) begin
						qd_q <= 9'sd0 - $signed(qmag);
						rd_q <= '0;
					end else begin
						qd_q <= $signed(qmag);
						rd_q <= div_rsp.remainder;
					end
					acc_q  <= '0;
					qa_q   <= '0;
					cnt_q  <= '0;
					time_q <= TW'(start_q);
				end
			end
			ST_RAMP: begin
				if (out_free) begin
					acc_q  <= acc_next[DIV_W-1:0];
					qa_q   <= qa_next;
					cnt_q  <= cnt_next;
					time_q <= time_q + TW'(sp);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RAMP || state_q == ST_TGT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: payload of one transaction.
	always_ff @(posedge clk) begin
		if (state_q == ST_RAMP && out_free) begin
			ctrl_out_q  <= ctrl_num_q;
			value_q     <= val_sum[6:0];
			etime_q     <= time_q;
			last_q      <= 1'b0;
			trunc_out_q <= trunc_q;
		end else if (state_q == ST_TGT && out_free) begin
			ctrl_out_q  <= ctrl_num_q;
			value_q     <= target_q;
			etime_q     <= short_q ? TW'(start_q) : end_time[TW-1:0];
			last_q      <= 1'b1;
			trunc_out_q <= trunc_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign controller = ctrl_out_q;
	assign value      = value_q;
	assign event_time = etime_q;
	assign last       = last_q;
	assign truncated  = trunc_out_q;

	// The divider is started only by the states that issue requests.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (state_q == ST_IDLE || state_q == ST_CHK || state_q == ST_SETUP))
		else $error("divider started from a waiting state");

	// A divider result arrives only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV_Q || state_q == ST_DIV_S || state_q == ST_DIV_D))
		else $error("divider result arrived outside a wait state");

	// The fractional accumulator stays below the step count during a ramp.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RAMP |-> acc_q < steps_q)
		else $error("ramp accumulator out of range");

	// A ramp emits between one and MAX_POINTS points.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RAMP |-> (emit_q != '0 && cnt_q < emit_q))
		else $error("ramp point count out of range");

	// The unit takes no input while a run is in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && is_note_on) |=> !in_ready)
		else $error("input accepted during a run");

endmodule

// File: verif/random_controller_sweep_unit_tb.sv
// Self-checking testbench of the random controller sweep unit with its scoreboard.
`timescale 1ns / 1ps

import rcs_pkg::*;

localparam int SWEEP_TIME_BITS  = 48;
localparam int SWEEP_MAX_POINTS = 63;

// One control change as the unit should produce it.
typedef struct {
	logic [6:0]               controller;
	logic [6:0]               value;
	logic [SWEEP_TIME_BITS:0] event_time;
	logic                     last;
	logic                     truncated;
} sweep_point_t;

// Mirrors the register file and the stored value, and holds the control changes still due.
class sweep_scoreboard;
	logic [6:0]   ctrl_num;
	logic [6:0]   min_val;
	logic [6:0]   max_val;
	logic [7:0]   mult;
	logic [23:0]  quantize;
	logic [2:0]   eighths;
	logic [8:0]   density;
	logic [6:0]   prev_value;
	sweep_point_t pending_points[$];
	int unsigned  failures;

	function new();
		ctrl_num   = 7'd10;
		min_val    = 7'd0;
		max_val    = 7'd127;
		mult       = 8'd1;
		quantize   = 24'd1;
		eighths    = 3'd2;
		density    = 9'd42;
		prev_value = 7'd64;
		failures   = 0;
	endfunction

	// A register write keeps only the bits of the register's width.
	function void write_reg(logic [2:0] index, logic [23:0] data);
		case (index)
			REG_CONTROLLER: ctrl_num = data[6:0];
			REG_LOW_BOUND: min_val = data[6:0];
			REG_HIGH_BOUND: max_val = data[6:0];
			REG_MULTIPLIER: mult = data[7:0];
			REG_QUANTIZE: quantize = data;
			REG_EIGHTHS: eighths = data[2:0];
			REG_DENSITY: density = data[8:0];
			default: ;
		endcase
	endfunction

	function void add_point(logic [6:0] val, logic [SWEEP_TIME_BITS:0] t, logic fin,
			logic cut);
		sweep_point_t pt;
		pt.controller = ctrl_num;
		pt.value      = val;
		pt.event_time = t;
		pt.last       = fin;
		pt.truncated  = cut;
		pending_points = {pending_points, pt};
	endfunction

	// Works out the run of control changes caused by one accepted input transaction.
	function void plan_sweep(logic note, logic [SWEEP_TIME_BITS-1:0] start, logic [15:0] draw);
		int unsigned       lo, hi, target, div;
		longint unsigned   dur, sp, n, steps, emit;
		longint            diff, num, quot;
		logic              cut;
		if (!note)
			return;
		lo = (min_val < max_val) ? min_val : max_val;
		hi = (min_val < max_val) ? max_val : min_val;
		target = lo + ((32'(draw) * (hi - lo)) >> 16);
		if (target > hi)
			target = hi;

		// Eighths values off the set fall to the next lower member; those below two become two.
		if (eighths <= 3'd2)
			div = 2;
		else if (eighths <= 3'd4)
			div = 3;
		else if (eighths <= 3'd6)
			div = 5;
		else
			div = 7;
		dur = longint'(mult) * ((2 * longint'(quantize)) / div);

		// A sweep of one tick or less is the target alone and keeps the stored value.
		if (dur <= 1) begin
			add_point(7'(target), (SWEEP_TIME_BITS+1)'(start), 1'b1, 1'b0);
			return;
		end

		sp    = ((density == 0) ? 1 : longint'(density)) * 10;
		n     = (dur + sp - 1) / sp;
		steps = dur / sp + 1;
		cut   = (n > SWEEP_MAX_POINTS);
		emit  = cut ? SWEEP_MAX_POINTS : n;
		diff  = longint'(target) - longint'(prev_value);

		// Ramp points use a floor division, also when the ramp goes down.
		for (longint unsigned c = 1; c <= emit; c++) begin
			num  = longint'(c) * diff;
			quot = num / longint'(steps);
			if ((num % longint'(steps)) != 0 && num < 0)
				quot -= 1;
			add_point(7'(longint'(prev_value) + quot),
				(SWEEP_TIME_BITS+1)'(start) + (SWEEP_TIME_BITS+1)'((c - 1) * sp), 1'b0, cut);
		end
		add_point(7'(target), (SWEEP_TIME_BITS+1)'(start) + (SWEEP_TIME_BITS+1)'(dur), 1'b1, cut);
		prev_value = 7'(target);
	endfunction

	// Compares one output transaction with the oldest control change still due.
	function void check_point(logic [6:0] ctrl, logic [6:0] val, logic [SWEEP_TIME_BITS:0] t,
			logic fin, logic cut);
		sweep_point_t due;
		if (pending_points.size() == 0) begin
			$error("control change with none due: value %0d at tick %0d", val, t);
			failures++;
			return;
		end
		due = pending_points.pop_front();
		if (ctrl !== due.controller) begin
			$error("controller: expected %0d, actual %0d", due.controller, ctrl);
			failures++;
		end
		if (val !== due.value) begin
			$error("value: expected %0d, actual %0d", due.value, val);
			failures++;
		end
		if (t !== due.event_time) begin
			$error("event_time: expected %0d, actual %0d", due.event_time, t);
			failures++;
		end
		if (fin !== due.last) begin
			$error("last: expected %0d, actual %0d", due.last, fin);
			failures++;
		end
		if (cut !== due.truncated) begin
			$error("truncated: expected %0d, actual %0d", due.truncated, cut);
			failures++;
		end
	endfunction
endclass

module random_controller_sweep_unit_tb;

	localparam logic [2:0]  REG_UNUSED    = 3'd7;
	localparam int          SETTLE_CYCLES = 200;
	localparam int          STUCK_LIMIT   = 3000;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [2:0]                 cfg_index;
	logic [23:0]                cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic                       is_note_on;
	logic [SWEEP_TIME_BITS-1:0] start_time;
	logic [15:0]                random_draw;
	logic                       out_valid;
	logic                       out_ready;
	logic [6:0]                 controller;
	logic [6:0]                 value;
	logic [SWEEP_TIME_BITS:0]   event_time;
	logic                       last;
	logic                       truncated;

	sweep_scoreboard sb;
	int unsigned     in_gap_pct;
	int unsigned     out_stall_pct;
	int unsigned     stall_left;
	int unsigned     stuck_cycles;

	random_controller_sweep_unit #(
		.MAX_POINTS(SWEEP_MAX_POINTS),
		.TIME_BITS (SWEEP_TIME_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.is_note_on (is_note_on),
		.start_time (start_time),
		.random_draw(random_draw),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.controller (controller),
		.value      (value),
		.event_time (event_time),
		.last       (last),
		.truncated  (truncated)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Idle stretches are mostly short, now and then long.
	function automatic int unsigned pause_len(int unsigned pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 19) < 16)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Output side: check every transaction and stall at random.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_point(controller, value, event_time, last, truncated);
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			stall_left = pause_len(out_stall_pct);
			out_ready <= (stall_left == 0);
		end
	end

	// Watchdog on cycles in which no channel moves a transaction.
	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// New idle odds for both sides; zero gives a stretch without idling.
	task automatic set_pace();
		int unsigned odds[4] = '{0, 10, 35, 70};
		in_gap_pct    = odds[$urandom_range(0, 3)];
		out_stall_pct = odds[$urandom_range(0, 3)];
	endtask

	// One register write; bits above the register's width carry random data.
	task automatic write_cfg(logic [2:0] index, logic [23:0] val, int width);
		int unsigned gap;
		logic [23:0] data;
		data = 24'(({$urandom} << width) | 32'(val));
		gap  = pause_len(in_gap_pct);
		if (gap != 0) begin
			cfg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(index, data);
	endtask

	// Writes every register, starting at a random one, now and then with a stray index too.
	task automatic configure(int unsigned cn, int unsigned mn, int unsigned mx, int unsigned mu,
			int unsigned qt, int unsigned ei, int unsigned de);
		logic [2:0]  idx[7] = '{REG_CONTROLLER, REG_LOW_BOUND, REG_HIGH_BOUND, REG_MULTIPLIER,
			REG_QUANTIZE, REG_EIGHTHS, REG_DENSITY};
		int unsigned vals[7];
		int          widths[7] = '{7, 7, 7, 8, 24, 3, 9};
		int unsigned rot;
		vals = '{cn, mn, mx, mu, qt, ei, de};
		rot  = $urandom_range(0, 6);
		if ($urandom_range(0, 1) == 1)
			write_cfg(REG_UNUSED, 24'($urandom), 0);
		for (int k = 0; k < 7; k++)
			write_cfg(idx[(k + rot) % 7], 24'(vals[(k + rot) % 7]), widths[(k + rot) % 7]);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_config(bit wild);
		if (wild)
			configure($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
				$urandom_range(0, 255), $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 7),
				$urandom_range(0, 511));
		else
			configure($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
				$urandom_range(0, 4), $urandom_range(0, 600), $urandom_range(0, 7),
				$urandom_range(0, 30));
	endtask

	// One input transaction; valid stays high for a back-to-back successor.
	task automatic send_item(logic note, logic [SWEEP_TIME_BITS-1:0] t, logic [15:0] draw);
		int unsigned gap;
		gap = pause_len(in_gap_pct);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		is_note_on  <= note;
		start_time  <= t;
		random_draw <= draw;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.plan_sweep(note, t, draw);
	endtask

	task automatic random_items(int count);
		logic [SWEEP_TIME_BITS-1:0] t;
		for (int k = 0; k < count; k++) begin
			t = SWEEP_TIME_BITS'({$urandom, $urandom});
			if ($urandom_range(0, 9) == 0)
				t = {SWEEP_TIME_BITS{1'b1}} - SWEEP_TIME_BITS'($urandom_range(0, 255));
			send_item($urandom_range(0, 99) < 85, t, 16'($urandom));
		end
	endtask

	// Lets the unit go idle: all due control changes seen, then a settling pause.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_points.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		sb            = new();
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		is_note_on    = 1'b0;
		start_time    = '0;
		random_draw   = '0;
		out_ready     = 1'b0;
		in_gap_pct    = 0;
		out_stall_pct = 0;
		stall_left    = 0;
		stuck_cycles  = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings give one-tick sweeps: the target alone at the start time.
		send_item(1'b0, SWEEP_TIME_BITS'({$urandom, $urandom}), 16'($urandom));
		send_item(1'b1, '0, 16'h0000);
		send_item(1'b1, {SWEEP_TIME_BITS{1'b1}}, 16'hFFFF);
		send_item(1'b1, SWEEP_TIME_BITS'({$urandom, $urandom}), 16'h8000);
		drain();

		// Long ramp cut short, first up from the reset value, then all the way down.
		set_pace();
		configure(127, 0, 127, 1, 1000, 2, 1);
		send_item(1'b1, '0, 16'hFFFF);
		send_item(1'b1, SWEEP_TIME_BITS'({$urandom, $urandom}), 16'h0000);
		drain();

		// Minimum above maximum, largest multiplier, quantize and spacing, latest start.
		set_pace();
		configure(0, 127, 0, 255, 24'hFFFFFF, 7, 511);
		send_item(1'b1, {SWEEP_TIME_BITS{1'b1}}, 16'h0000);
		send_item(1'b1, {SWEEP_TIME_BITS{1'b1}}, 16'hFFFF);
		drain();

		// Density zero and a sweep that is an exact multiple of the spacing.
		set_pace();
		configure(5, 20, 100, 3, 100, 6, 0);
		send_item(1'b1, SWEEP_TIME_BITS'($urandom), 16'($urandom));
		send_item(1'b0, SWEEP_TIME_BITS'($urandom), 16'($urandom));
		send_item(1'b1, SWEEP_TIME_BITS'($urandom), 16'($urandom));
		send_item(1'b1, SWEEP_TIME_BITS'($urandom), 16'($urandom));
		drain();

		// Shortest sweep that still ramps: two ticks, one step.
		set_pace();
		configure(64, 90, 30, 2, 1, 1, 1);
		send_item(1'b1, SWEEP_TIME_BITS'($urandom), 16'h0000);
		send_item(1'b1, SWEEP_TIME_BITS'($urandom), 16'hFFFF);
		drain();

		// Zero multiplier and zero quantize both collapse the sweep.
		set_pace();
		configure(1, 50, 50, 0, 5, 0, 7);
		send_item(1'b1, SWEEP_TIME_BITS'($urandom), 16'($urandom));
		drain();
		set_pace();
		configure(2, 50, 50, 9, 0, 3, 7);
		send_item(1'b1, SWEEP_TIME_BITS'($urandom), 16'($urandom));
		drain();

		// Eighths four acts as three; spacing wider than the sweep.
		set_pace();
		configure(100, 10, 120, 1, 10, 4, 400);
		send_item(1'b1, SWEEP_TIME_BITS'($urandom), 16'($urandom));
		send_item(1'b1, SWEEP_TIME_BITS'($urandom), 16'($urandom));
		drain();

		// Random phases, mostly moderate settings and a couple of wild ones.
		for (int ph = 0; ph < 8; ph++) begin
			set_pace();
			random_config(ph == 3 || ph == 6);
			random_items(14);
			drain();
		end

		if (sb.failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/rcs_pkg.sv
hw/rtl/rcs_div.sv
hw/rtl/random_controller_sweep_unit.sv
verif/random_controller_sweep_unit_tb.sv
